// ===== rtl/ksem_pkg.sv =====
// ---------------------------------------------------------------------------
// ksem_pkg
// shared types and codes for the keyed semaphore table
// ---------------------------------------------------------------------------
package ksem_pkg;

  localparam logic [22:0] HANDLE_BASE = 23'h575000;

  typedef enum logic [2:0] {
    OP_GET_OR_CREATE = 3'd0,
    OP_SET           = 3'd1,
    OP_READ_VALUE    = 3'd2,
    OP_READ_PID      = 3'd3,
    OP_READ_NEG      = 3'd4,
    OP_READ_ZERO     = 3'd5,
    OP_REMOVE        = 3'd6,
    OP_OPERATE       = 3'd7
  } ksem_op_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_INVALID     = 3'd1;
  localparam logic [2:0] ST_EXISTS      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_NO_SPACE    = 3'd4;
  localparam logic [2:0] ST_TOO_BIG     = 3'd5;
  localparam logic [2:0] ST_WOULD_BLOCK = 3'd6;
  localparam logic [2:0] ST_TRY_AGAIN   = 3'd7;

  typedef enum logic [1:0] {
    OUT_POSSIBLE = 2'd0,
    OUT_BLOCKED  = 2'd1,
    OUT_TOO_BIG  = 2'd2,
    OUT_INVALID  = 2'd3
  } ksem_outcome_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_CMD_EX,
    S_OP_EX
  } ksem_state_t;

  typedef struct packed {
    ksem_op_t    opcode;
    logic [30:0] handle;
    logic [31:0] key;
    logic [15:0] sem_count;
    logic        create_flag;
    logic        exclusive_flag;
    logic [31:0] set_value;
    logic [15:0] sem_member;
    logic [15:0] op_value;
    logic        nowait_flag;
    logic        last_op;
  } ksem_item_t;

  typedef struct packed {
    logic valid;
    logic in_range;
  } ksem_head_t;

endpackage

// ===== rtl/ksem_ram.sv =====
// ---------------------------------------------------------------------------
// ksem_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module ksem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ksem_front.sv =====
// ---------------------------------------------------------------------------
// ksem_front
// input queue of two words; decodes the handle range on entry
// ---------------------------------------------------------------------------
module ksem_front #(
  parameter int SLOTS = 64,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  ksem_pkg::ksem_item_t item,
  output ksem_pkg::ksem_head_t head,
  output ksem_pkg::ksem_item_t head_item,
  output logic [IW-1:0]       head_idx,
  input  logic                pop
);

  ksem_pkg::ksem_item_t q_item_r [2];
  logic                 q_rng_r  [2];
  logic [IW-1:0]        q_idx_r  [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic [31:0]          diff;
  logic                 rng;
  logic                 do_push, do_pop;

  assign diff = {1'b0, item.handle} - {9'd0, ksem_pkg::HANDLE_BASE};
  assign rng  = ({1'b0, item.handle} >= {9'd0, ksem_pkg::HANDLE_BASE}) &&
                (diff < 32'(SLOTS));

  assign full    = (cnt_r == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop && (cnt_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_item_r[wr_ptr_r] <= item;
      q_rng_r[wr_ptr_r]  <= rng;
      q_idx_r[wr_ptr_r]  <= diff[IW-1:0];
    end
  end

  assign head.valid    = (cnt_r != 2'd0);
  assign head.in_range = q_rng_r[rd_ptr_r];
  assign head_item     = q_item_r[rd_ptr_r];
  assign head_idx      = q_idx_r[rd_ptr_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r)) else $error("queue pointers disagree");

  a_pop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |=> full) else $error("full dropped without pop");

endmodule

// ===== rtl/ksem_back.sv =====
// ---------------------------------------------------------------------------
// ksem_back
// sequencer that executes commands and operation runs against the table
// ---------------------------------------------------------------------------
module ksem_back #(
  parameter int SLOTS = 64,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ksem_pkg::ksem_head_t head,
  input  ksem_pkg::ksem_item_t head_item,
  input  logic [IW-1:0]        head_idx,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_take,
  output logic [2:0]           status,
  output logic [22:0]          handle_out,
  output logic signed [31:0]   read_value,
  output logic                 wake
);

  ksem_pkg::ksem_state_t   state_r, state_nxt;
  ksem_pkg::ksem_item_t    cmd_r, cmd_nxt;
  logic [IW-1:0]           cidx_r, cidx_nxt;
  logic [IW-1:0]           scan_r, scan_nxt;
  logic                    ffree_r, ffree_nxt;
  logic [IW-1:0]           fidx_r, fidx_nxt;
  logic [SLOTS-1:0]        used_r, used_nxt;
  logic                    pact_r, pact_nxt;
  logic [31:0]             pval_r, pval_nxt;
  logic [IW-1:0]           pslot_r, pslot_nxt;
  ksem_pkg::ksem_outcome_t pout_r, pout_nxt;
  logic                    pnw_r, pnw_nxt;
  logic                    first_r, first_nxt;
  logic                    ov_r, ov_nxt;
  logic [2:0]              ost_r, ost_nxt;
  logic [22:0]             oh_r, oh_nxt;
  logic [31:0]             orv_r, orv_nxt;
  logic                    ow_r, ow_nxt;

  logic [IW-1:0] raddr, waddr, kwaddr;
  logic          we, kwe;
  logic [63:0]   wdata, rdata;
  logic [31:0]   krdata;

  logic          hok, hit, free_here, ffree_eff;
  logic [IW-1:0] fidx_eff;
  logic [31:0]   pv, pv_add, rval;
  logic [15:0]   rneg, rzero;
  logic [32:0]   chk;
  logic          nw;

  ksem_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_row (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  ksem_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_key (
    .clk, .we(kwe), .waddr(kwaddr), .wdata(cmd_r.key), .raddr, .rdata(krdata)
  );

  assign rval  = rdata[63:32];
  assign rneg  = rdata[31:16];
  assign rzero = rdata[15:0];

  assign hok       = head.in_range && used_r[head_idx];
  assign hit       = used_r[scan_r] && (cmd_r.key != 32'd0) && (krdata == cmd_r.key);
  assign free_here = !used_r[scan_r];
  assign ffree_eff = ffree_r || free_here;
  assign fidx_eff  = ffree_r ? fidx_r : scan_r;

  assign pv     = first_r ? rval : pval_r;
  assign pv_add = pv + {{16{cmd_r.op_value[15]}}, cmd_r.op_value};
  assign chk    = {pv[31], pv} + {{17{cmd_r.op_value[15]}}, cmd_r.op_value};
  assign nw     = pnw_r | cmd_r.nowait_flag;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cidx_nxt  = cidx_r;
    scan_nxt  = scan_r;
    ffree_nxt = ffree_r;
    fidx_nxt  = fidx_r;
    used_nxt  = used_r;
    pact_nxt  = pact_r;
    pval_nxt  = pval_r;
    pslot_nxt = pslot_r;
    pout_nxt  = pout_r;
    pnw_nxt   = pnw_r;
    first_nxt = first_r;
    ov_nxt    = ov_r && !out_take;
    ost_nxt   = ost_r;
    oh_nxt    = oh_r;
    orv_nxt   = orv_r;
    ow_nxt    = ow_r;
    pop       = 1'b0;
    raddr     = head_idx;
    we        = 1'b0;
    waddr     = cidx_r;
    wdata     = 64'd0;
    kwe       = 1'b0;
    kwaddr    = fidx_eff;

    unique case (state_r)
      ksem_pkg::S_IDLE: begin
        if (head.valid && !ov_r) begin
          pop      = 1'b1;
          cmd_nxt  = head_item;
          cidx_nxt = head_idx;
          ost_nxt  = ksem_pkg::ST_INVALID;
          oh_nxt   = 23'd0;
          orv_nxt  = 32'd0;
          ow_nxt   = 1'b0;
          if (head_item.opcode == ksem_pkg::OP_OPERATE) begin
            if (!pact_r) begin
              pact_nxt  = 1'b1;
              pnw_nxt   = 1'b0;
              first_nxt = hok;
              if (hok) begin
                pout_nxt  = ksem_pkg::OUT_POSSIBLE;
                pslot_nxt = head_idx;
              end else begin
                pout_nxt  = ksem_pkg::OUT_INVALID;
                pslot_nxt = '0;
                pval_nxt  = 32'd0;
              end
            end else begin
              first_nxt = 1'b0;
              raddr     = pslot_r;
            end
            state_nxt = ksem_pkg::S_OP_EX;
          end else if (head_item.opcode == ksem_pkg::OP_GET_OR_CREATE) begin
            pact_nxt = 1'b0;
            if (head_item.sem_count != 16'd1) begin
              ov_nxt = 1'b1;
            end else begin
              scan_nxt  = '0;
              ffree_nxt = 1'b0;
              state_nxt = ksem_pkg::S_SCAN_RD;
            end
          end else begin
            pact_nxt = 1'b0;
            if (!hok) begin
              ov_nxt = 1'b1;
            end else begin
              state_nxt = ksem_pkg::S_CMD_EX;
            end
          end
        end
      end
      ksem_pkg::S_SCAN_RD: begin
        raddr     = scan_r;
        state_nxt = ksem_pkg::S_SCAN_CMP;
      end
      ksem_pkg::S_SCAN_CMP: begin
        raddr = scan_r;
        if (hit) begin
          ov_nxt    = 1'b1;
          state_nxt = ksem_pkg::S_IDLE;
          if (cmd_r.create_flag && cmd_r.exclusive_flag) begin
            ost_nxt = ksem_pkg::ST_EXISTS;
          end else begin
            ost_nxt = ksem_pkg::ST_OK;
            oh_nxt  = ksem_pkg::HANDLE_BASE + 23'(scan_r);
          end
        end else if (scan_r == IW'(SLOTS - 1)) begin
          ov_nxt    = 1'b1;
          state_nxt = ksem_pkg::S_IDLE;
          if (cmd_r.key != 32'd0 && !cmd_r.create_flag) begin
            ost_nxt = ksem_pkg::ST_NOT_FOUND;
          end else if (ffree_eff) begin
            used_nxt[fidx_eff] = 1'b1;
            kwe     = 1'b1;
            we      = 1'b1;
            waddr   = fidx_eff;
            wdata   = 64'd0;
            ost_nxt = ksem_pkg::ST_OK;
            oh_nxt  = ksem_pkg::HANDLE_BASE + 23'(fidx_eff);
          end else begin
            ost_nxt = ksem_pkg::ST_NO_SPACE;
          end
        end else begin
          ffree_nxt = ffree_eff;
          fidx_nxt  = fidx_eff;
          scan_nxt  = scan_r + 1'b1;
          state_nxt = ksem_pkg::S_SCAN_RD;
        end
      end
      ksem_pkg::S_CMD_EX: begin
        ov_nxt    = 1'b1;
        ost_nxt   = ksem_pkg::ST_OK;
        state_nxt = ksem_pkg::S_IDLE;
        unique case (cmd_r.opcode)
          ksem_pkg::OP_SET: begin
            we     = 1'b1;
            wdata  = {cmd_r.set_value, 32'd0};
            ow_nxt = 1'b1;
          end
          ksem_pkg::OP_READ_VALUE: orv_nxt = rval;
          ksem_pkg::OP_READ_NEG:   orv_nxt = {16'd0, rneg};
          ksem_pkg::OP_READ_ZERO:  orv_nxt = {16'd0, rzero};
          ksem_pkg::OP_REMOVE: begin
            used_nxt[cidx_r] = 1'b0;
            ow_nxt           = 1'b1;
          end
          default: orv_nxt = 32'd0;
        endcase
      end
      ksem_pkg::S_OP_EX: begin
        pnw_nxt  = nw;
        pval_nxt = pv;
        waddr    = pslot_r;
        if (pout_r == ksem_pkg::OUT_POSSIBLE) begin
          priority if (cmd_r.sem_member != 16'd0) begin
            pout_nxt = ksem_pkg::OUT_TOO_BIG;
          end else if (cmd_r.op_value[15] && chk[32]) begin
            pout_nxt = ksem_pkg::OUT_BLOCKED;
            we       = 1'b1;
            wdata    = {rval, rneg + 16'd1, rzero};
          end else if (cmd_r.op_value == 16'd0 && pv != 32'd0) begin
            pout_nxt = ksem_pkg::OUT_BLOCKED;
            we       = 1'b1;
            wdata    = {rval, rneg, rzero + 16'd1};
          end else begin
            pval_nxt = pv_add;
          end
        end
        first_nxt = 1'b0;
        state_nxt = ksem_pkg::S_IDLE;
        if (cmd_r.last_op) begin
          pact_nxt = 1'b0;
          ov_nxt   = 1'b1;
          unique case (pout_nxt)
            ksem_pkg::OUT_INVALID: ost_nxt = ksem_pkg::ST_INVALID;
            ksem_pkg::OUT_TOO_BIG: ost_nxt = ksem_pkg::ST_TOO_BIG;
            ksem_pkg::OUT_BLOCKED:
              ost_nxt = nw ? ksem_pkg::ST_TRY_AGAIN : ksem_pkg::ST_WOULD_BLOCK;
            default: begin
              ost_nxt = ksem_pkg::ST_OK;
              ow_nxt  = 1'b1;
              we      = 1'b1;
              wdata   = {pval_nxt, 32'd0};
            end
          endcase
        end
      end
      default: state_nxt = ksem_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ksem_pkg::S_IDLE;
      used_r  <= '0;
      pact_r  <= 1'b0;
      pval_r  <= 32'd0;
      pslot_r <= '0;
      pout_r  <= ksem_pkg::OUT_POSSIBLE;
      pnw_r   <= 1'b0;
      first_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      pact_r  <= pact_nxt;
      pval_r  <= pval_nxt;
      pslot_r <= pslot_nxt;
      pout_r  <= pout_nxt;
      pnw_r   <= pnw_nxt;
      first_r <= first_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    cidx_r  <= cidx_nxt;
    scan_r  <= scan_nxt;
    ffree_r <= ffree_nxt;
    fidx_r  <= fidx_nxt;
    ost_r   <= ost_nxt;
    oh_r    <= oh_nxt;
    orv_r   <= orv_nxt;
    ow_r    <= ow_nxt;
  end

  assign out_valid  = ov_r;
  assign status     = ost_r;
  assign handle_out = oh_r;
  assign read_value = orv_r;
  assign wake       = ow_r;

  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ksem_pkg::S_IDLE) |-> !ov_r) else $error("result held while busy");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (we || kwe) |-> (state_r != ksem_pkg::S_IDLE)) else $error("table write while idle");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pslot_r) < 32'(SLOTS)) else $error("pending slot out of range");

  a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ow_r) |-> (ost_r == ksem_pkg::ST_OK)) else $error("wake on failed word");

endmodule

// ===== rtl/keyed_semaphore_table_core.sv =====
// ---------------------------------------------------------------------------
// keyed_semaphore_table_core
// table of keyed single semaphores with atomic operation runs
// ---------------------------------------------------------------------------
// Words enter a two-word input queue and are executed one at a time by a
// sequencer; the result waits in an output register while the queue keeps
// accepting. Set, reads and remove are rejected on their handle, and
// get-or-create on its count; an operate word answers only on the word
// that closes its run. Get-or-create walks the key store one slot at a
// time (one ram read state, then one compare state) and stops on a hit.
// No clearing pass after reset.
module keyed_semaphore_table_core #(
  parameter int SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [2:0]         in_opcode,
  input  logic [30:0]        in_handle,
  input  logic [31:0]        in_key,
  input  logic [15:0]        in_sem_count,
  input  logic               in_create_flag,
  input  logic               in_exclusive_flag,
  input  logic signed [31:0] in_set_value,
  input  logic [15:0]        in_sem_member,
  input  logic signed [15:0] in_op_value,
  input  logic               in_nowait_flag,
  input  logic               in_last_op,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [2:0]         out_status,
  output logic [22:0]        out_handle_out,
  output logic signed [31:0] out_read_value,
  output logic               out_wake
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ksem_pkg::ksem_item_t item, head_item;
  ksem_pkg::ksem_head_t head;
  logic [IW-1:0]        head_idx;
  logic                 pop, out_valid;

  always_comb begin
    item.opcode         = ksem_pkg::ksem_op_t'(in_opcode);
    item.handle         = in_handle;
    item.key            = in_key;
    item.sem_count      = in_sem_count;
    item.create_flag    = in_create_flag;
    item.exclusive_flag = in_exclusive_flag;
    item.set_value      = in_set_value;
    item.sem_member     = in_sem_member;
    item.op_value       = in_op_value;
    item.nowait_flag    = in_nowait_flag;
    item.last_op        = in_last_op;
  end

  ksem_front #(.SLOTS(SLOTS)) u_front (
    .clk, .rst_n, .push(in_push), .full(in_full), .item,
    .head, .head_item, .head_idx, .pop
  );

  ksem_back #(.SLOTS(SLOTS)) u_back (
    .clk, .rst_n, .head, .head_item, .head_idx, .pop,
    .out_valid, .out_take(out_pop),
    .status(out_status), .handle_out(out_handle_out),
    .read_value(out_read_value), .wake(out_wake)
  );

  assign out_empty = !out_valid;

endmodule
